### src/dls_pkg.sv
// dls_pkg: shared widths, codes, controller types and sigmoid table builder
// for the dense layer with sigmoid activation; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dls_pkg;

  localparam int MAX_NEURONS_DEF   = 64;
  localparam int MAX_INPUTS_DEF    = 256;
  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int DATA_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int ACT_W    = 13;
  localparam int NEURON_W = 6;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int UOFF_W   = 28;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_FEED = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SUM_LO  = {{(ACC_W-27){1'b1}}, 27'd0};
  localparam logic signed [ACC_W-1:0] SUM_HI  = {{(ACC_W-27){1'b0}}, {27{1'b1}}};

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_MAC        = 5'b00010,
    ST_MAC_DRAIN  = 5'b00100,
    ST_EMIT       = 5'b01000,
    ST_EMIT_DRAIN = 5'b10000
  } dls_state_t;

  typedef struct packed {
    logic                load_weight;
    logic                load_act;
    logic                mac_issue;
    logic                emit_issue;
    logic                emit_last;
    logic                clear_acc;
    logic [NEURON_W-1:0] idx;
  } dls_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dls_sts_t;

  // e^-f in q.32 by alternating series
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int K = 1; K <= 13; K++) begin
      term = ((term * f) >> 32) / 64'(K);
      if (K % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // sigmoid sample at the center of bin i, unsigned q1.12
  function automatic logic [ACT_W-1:0] sigmoid_entry(input int unsigned i,
                                                     input int unsigned Entries);
    logic [63:0] half;
    logic [63:0] em1;
    logic [63:0] c;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] en;
    logic [63:0] e;
    logic [63:0] Den;
    logic [63:0] s;
    half = exp_neg_frac(64'd1 << 31);
    em1  = (half * half) >> 32;
    c    = 64'(2 * i + 1);
    neg  = c < 64'(Entries);
    mag  = neg ? (64'(Entries) - c) : (c - 64'(Entries));
    a    = (mag << 35) / 64'(Entries);
    n    = a >> 32;
    en   = 64'd1 << 32;
    for (int j = 0; j < 8; j++) begin
      if (64'(j) < n) begin
        en = (en * em1) >> 32;
      end
    end
    e   = (en * exp_neg_frac({32'd0, a[31:0]})) >> 32;
    Den = (64'd1 << 32) + e;
    s   = ((64'd1 << 44) + Den / 2) / Den;
    if (neg) begin
      s = 64'd4096 - s;
    end
    return s[ACT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/dls_ctrl.sv
// dls_ctrl: sequencer for weight loads, neuron accumulate sweeps and result sweeps
// depends on dls_pkg
`timescale 1ns / 1ps
`default_nettype none

module dls_ctrl #(
  parameter int MAX_NEURONS = dls_pkg::MAX_NEURONS_DEF,
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [dls_pkg::NEURON_W-1:0] in_neuron_index,
  input  wire logic [dls_pkg::INDEX_W-1:0]  in_input_index,
  input  wire logic                         in_last_input,
  input  wire logic                         cfg_we,
  input  wire logic [dls_pkg::COUNT_W-1:0]  cfg_wdata,
  output dls_pkg::dls_cmd_t                 cmd,
  input  dls_pkg::dls_sts_t                 sts
);

  dls_pkg::dls_state_t               state_r, state_nxt;
  logic [dls_pkg::NEURON_W-1:0]      cnt_r, cnt_nxt;
  logic                              last_r, last_nxt;
  logic [dls_pkg::COUNT_W-1:0]       out_count_r;
  logic [dls_pkg::COUNT_W-1:0]       count_lim;
  logic                              accept;
  logic                              row_ok;
  logic                              col_ok;
  logic                              emit_end;

  assign accept = start && (state_r == dls_pkg::ST_IDLE);
  assign busy   = (state_r != dls_pkg::ST_IDLE);
  assign row_ok = 32'(in_neuron_index) < MAX_NEURONS;
  assign col_ok = 32'(in_input_index) < MAX_INPUTS;

  always_comb begin
    if (out_count_r == '0) begin
      count_lim = dls_pkg::COUNT_W'(1);
    end else if (32'(out_count_r) > MAX_NEURONS) begin
      count_lim = dls_pkg::COUNT_W'(MAX_NEURONS);
    end else begin
      count_lim = out_count_r;
    end
  end

  assign emit_end = (dls_pkg::COUNT_W'(cnt_r) + dls_pkg::COUNT_W'(1)) == count_lim;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    last_nxt        = last_r;
    cmd             = '0;
    cmd.idx         = cnt_r;
    cmd.load_weight = accept && (in_func == dls_pkg::FUNC_LOAD) && row_ok && col_ok;
    cmd.load_act    = accept && (in_func == dls_pkg::FUNC_FEED);
    unique case (state_r)
      dls_pkg::ST_IDLE: begin
        if (cmd.load_act) begin
          last_nxt = in_last_input;
          cnt_nxt  = '0;
          if (col_ok) begin
            state_nxt = dls_pkg::ST_MAC;
          end else if (in_last_input) begin
            state_nxt = dls_pkg::ST_EMIT;
          end
        end
      end
      dls_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (32'(cnt_r) == MAX_NEURONS - 1) begin
          state_nxt = dls_pkg::ST_MAC_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + dls_pkg::NEURON_W'(1);
        end
      end
      dls_pkg::ST_MAC_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = last_r ? dls_pkg::ST_EMIT : dls_pkg::ST_IDLE;
        end
      end
      dls_pkg::ST_EMIT: begin
        cmd.emit_issue = 1'b1;
        cmd.emit_last  = emit_end;
        if (emit_end) begin
          state_nxt = dls_pkg::ST_EMIT_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + dls_pkg::NEURON_W'(1);
        end
      end
      dls_pkg::ST_EMIT_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.clear_acc = 1'b1;
          state_nxt     = dls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dls_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_count_r <= dls_pkg::COUNT_W'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        out_count_r <= cfg_wdata;
      end
    end
  end

  a_last_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |-> cmd.emit_issue)
    else $error("emit_last outside an emit beat");

  a_mac_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mac_issue && (32'(cmd.idx) == MAX_NEURONS - 1)) |=>
      (state_r == dls_pkg::ST_MAC_DRAIN))
    else $error("mac sweep did not end in drain");

  a_emit_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |=> (state_r == dls_pkg::ST_EMIT_DRAIN))
    else $error("emit sweep did not end in drain");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_acc |=> (state_r == dls_pkg::ST_IDLE) && !sts.pipe_busy)
    else $error("accumulators cleared with work in flight");

endmodule

`default_nettype wire

### src/dls_datapath.sv
// dls_datapath: weight and accumulator memories, shared multiply-accumulate
// pipeline and sigmoid lookup pipeline; depends on dls_pkg
`timescale 1ns / 1ps
`default_nettype none

module dls_datapath #(
  parameter int MAX_NEURONS   = dls_pkg::MAX_NEURONS_DEF,
  parameter int MAX_INPUTS    = dls_pkg::MAX_INPUTS_DEF,
  parameter int TABLE_ENTRIES = dls_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [dls_pkg::NEURON_W-1:0]      in_neuron_index,
  input  wire logic [dls_pkg::INDEX_W-1:0]       in_input_index,
  input  wire logic signed [dls_pkg::DATA_W-1:0] in_data,
  input  dls_pkg::dls_cmd_t                      cmd,
  output dls_pkg::dls_sts_t                      sts,
  output logic                                   out_valid,
  output logic [dls_pkg::NEURON_W-1:0]           out_neuron,
  output logic [dls_pkg::ACT_W-1:0]              out_activation,
  output logic                                   out_last
);

  localparam int AW     = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int TIDX_W = $clog2(TABLE_ENTRIES);
  localparam int TF_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int PT_W   = dls_pkg::UOFF_W + TF_W;

  typedef logic [dls_pkg::ACT_W-1:0] sig_tab_t [TABLE_ENTRIES];

  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tab[i] = dls_pkg::sigmoid_entry(i, TABLE_ENTRIES);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

  logic signed [dls_pkg::DATA_W-1:0] w_mem [WDEPTH];
  logic signed [dls_pkg::ACC_W-1:0]  acc_mem [MAX_NEURONS];
  logic [MAX_NEURONS-1:0]            acc_vld_r;

  logic [WA_W-1:0]                   w_wr_addr;
  logic [WA_W-1:0]                   w_rd_addr;
  logic [AW-1:0]                     rd_a;
  logic [dls_pkg::INDEX_W-1:0]       col_r;
  logic signed [dls_pkg::DATA_W-1:0] act_r;

  logic signed [dls_pkg::DATA_W-1:0] w_q_r;
  logic signed [dls_pkg::ACC_W-1:0]  acc_q_r;
  logic                              vld_q_r;

  logic                              m1_v_r, m2_v_r;
  logic [AW-1:0]                     m1_idx_r, m2_idx_r;
  logic signed [dls_pkg::PROD_W-1:0] prod_r;
  logic signed [dls_pkg::ACC_W-1:0]  base_r;
  logic signed [dls_pkg::ACC_W:0]    mac_sum;
  logic signed [dls_pkg::ACC_W-1:0]  mac_sat;

  logic                              e1_v_r, e2_v_r;
  logic                              e1_last_r, e2_last_r, e3_last_r;
  logic [dls_pkg::NEURON_W-1:0]      e1_n_r, e2_n_r, e3_n_r;
  logic [dls_pkg::UOFF_W-1:0]        u_r;
  logic [PT_W-1:0]                   pt;
  logic signed [dls_pkg::ACC_W-1:0]  e_sum;
  logic signed [dls_pkg::ACC_W-1:0]  e_clamp;
  logic [TF_W-1:0]                   t_full;
  logic [TIDX_W-1:0]                 t_idx;
  logic                              o_v_r;
  logic [dls_pkg::ACT_W-1:0]         o_act_r;

  assign w_wr_addr = WA_W'(32'(in_neuron_index) * MAX_INPUTS + 32'(in_input_index));
  assign w_rd_addr = WA_W'(32'(cmd.idx) * MAX_INPUTS + 32'(col_r));
  assign rd_a      = cmd.idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_act) begin
      col_r <= in_input_index;
      act_r <= in_data;
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (cmd.load_weight) begin
      w_mem[w_wr_addr] <= in_data;
    end
    w_q_r <= w_mem[w_rd_addr];
  end

  // accumulator store, one read port shared by both sweeps
  always_ff @(posedge clk) begin
    if (m2_v_r) begin
      acc_mem[m2_idx_r] <= mac_sat;
    end
    acc_q_r <= acc_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      vld_q_r <= acc_vld_r[rd_a];
      if (cmd.clear_acc) begin
        acc_vld_r <= '0;
      end else if (m2_v_r) begin
        acc_vld_r[m2_idx_r] <= 1'b1;
      end
    end
  end

  // multiply-accumulate pipeline
  always_comb begin
    mac_sum = {base_r[dls_pkg::ACC_W-1], base_r} + (dls_pkg::ACC_W + 1)'(prod_r);
    if (mac_sum[dls_pkg::ACC_W] != mac_sum[dls_pkg::ACC_W-1]) begin
      mac_sat = mac_sum[dls_pkg::ACC_W] ? dls_pkg::ACC_MIN : dls_pkg::ACC_MAX;
    end else begin
      mac_sat = mac_sum[dls_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m1_idx_r <= rd_a;
    m2_idx_r <= m1_idx_r;
    prod_r   <= w_q_r * act_r;
    base_r   <= vld_q_r ? acc_q_r : '0;
  end

  // sigmoid lookup pipeline
  always_comb begin
    e_sum = vld_q_r ? acc_q_r : '0;
    priority if (e_sum < dls_pkg::SUM_LO) begin
      e_clamp = dls_pkg::SUM_LO;
    end else if (e_sum > dls_pkg::SUM_HI) begin
      e_clamp = dls_pkg::SUM_HI;
    end else begin
      e_clamp = e_sum;
    end
  end

  assign pt     = PT_W'(u_r) * PT_W'(TABLE_ENTRIES);
  assign t_full = pt[PT_W-1:dls_pkg::UOFF_W];
  assign t_idx  = (32'(t_full) >= TABLE_ENTRIES) ? TIDX_W'(TABLE_ENTRIES - 1)
                                                 : t_full[TIDX_W-1:0];

  always_ff @(posedge clk) begin
    e1_n_r    <= cmd.idx;
    e1_last_r <= cmd.emit_last;
    e2_n_r    <= e1_n_r;
    e2_last_r <= e1_last_r;
    e3_n_r    <= e2_n_r;
    e3_last_r <= e2_last_r;
    u_r       <= {~e_clamp[dls_pkg::UOFF_W-1], e_clamp[dls_pkg::UOFF_W-2:0]};
    o_act_r   <= SIG_TABLE[t_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      m1_v_r <= cmd.mac_issue;
      m2_v_r <= m1_v_r;
      e1_v_r <= cmd.emit_issue;
      e2_v_r <= e1_v_r;
      o_v_r  <= e2_v_r;
    end
  end

  assign sts.pipe_busy  = m1_v_r || m2_v_r || e1_v_r || e2_v_r;
  assign out_valid      = o_v_r;
  assign out_neuron     = e3_n_r;
  assign out_activation = o_act_r;
  assign out_last       = o_v_r && e3_last_r;

  a_sweeps_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !((m1_v_r || m2_v_r) && (e1_v_r || e2_v_r || cmd.emit_issue)))
    else $error("mac and sigmoid sweeps overlap");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_acc |-> !m2_v_r && !cmd.mac_issue)
    else $error("accumulator clear during a write");

  a_out_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.emit_issue, 3) |-> out_valid)
    else $error("emit beat produced no result");

endmodule

`default_nettype wire

### src/dense_layer_sigmoid.sv
// dense_layer_sigmoid: one fully connected layer without bias and sigmoid output
// weight loads leave busy low; an in-range activation keeps busy high while
// one shared multiply-accumulate sweeps all neurons; a last activation then
// emits out_count results (min 1, max MAX_NEURONS), one per cycle via stages
// e1, e2 and out, as single-cycle out_valid beats that cannot stall
// reset: out_count = 1, accumulators read as zero, weights undefined until written
`timescale 1ns / 1ps
`default_nettype none

module dense_layer_sigmoid #(
  parameter int MAX_NEURONS   = dls_pkg::MAX_NEURONS_DEF,
  parameter int MAX_INPUTS    = dls_pkg::MAX_INPUTS_DEF,
  parameter int TABLE_ENTRIES = dls_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_func,
  input  wire logic [dls_pkg::NEURON_W-1:0]      in_neuron_index,
  input  wire logic [dls_pkg::INDEX_W-1:0]       in_input_index,
  input  wire logic signed [dls_pkg::DATA_W-1:0] in_data,
  input  wire logic                              in_last_input,
  output logic                                   out_valid,
  output logic [dls_pkg::NEURON_W-1:0]           out_neuron,
  output logic [dls_pkg::ACT_W-1:0]              out_activation,
  output logic                                   out_last,
  input  wire logic                              cfg_we,
  input  wire logic [dls_pkg::COUNT_W-1:0]       cfg_wdata
);

  dls_pkg::dls_cmd_t cmd;
  dls_pkg::dls_sts_t sts;

  dls_ctrl #(
    .MAX_NEURONS (MAX_NEURONS),
    .MAX_INPUTS  (MAX_INPUTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_neuron_index (in_neuron_index),
    .in_input_index  (in_input_index),
    .in_last_input   (in_last_input),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts)
  );

  dls_datapath #(
    .MAX_NEURONS   (MAX_NEURONS),
    .MAX_INPUTS    (MAX_INPUTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_neuron_index (in_neuron_index),
    .in_input_index  (in_input_index),
    .in_data         (in_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_neuron      (out_neuron),
    .out_activation  (out_activation),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

### bench/dense_layer_sigmoid_test.sv
`timescale 1ns / 1ps
// dense_layer_sigmoid_test: self-checking bench for the dense layer with sigmoid output,
// predicting every neuron result from weight and activation beats and checking them in order
// depends on dls_pkg and dense_layer_sigmoid

module dense_layer_sigmoid_test;
  import dls_pkg::*;

  localparam int NEURONS      = MAX_NEURONS_DEF;
  localparam int INPUTS       = MAX_INPUTS_DEF;
  localparam int LUT_SIZE     = TABLE_ENTRIES_DEF;
  localparam int LUT_SHIFT    = UOFF_W - $clog2(LUT_SIZE);
  localparam int DRAIN_CYCLES = NEURONS + 16;

  typedef struct packed {
    logic                       func;
    logic [NEURON_W-1:0]        row;
    logic [INDEX_W-1:0]         col;
    logic signed [DATA_W-1:0]   data;
    logic                       last_in;
  } layer_beat_t;

  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic [ACT_W-1:0]    act;
    logic                is_last;
  } neuron_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_func = FUNC_LOAD;
  logic [NEURON_W-1:0]      in_neuron_index = '0;
  logic [INDEX_W-1:0]       in_input_index = '0;
  logic signed [DATA_W-1:0] in_data = '0;
  logic                     in_last_input = 1'b0;
  logic                     out_valid;
  logic [NEURON_W-1:0]      out_neuron;
  logic [ACT_W-1:0]         out_activation;
  logic                     out_last;
  logic                     cfg_we = 1'b0;
  logic [COUNT_W-1:0]       cfg_wdata = '0;

  dense_layer_sigmoid i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_neuron_index(in_neuron_index),
    .in_input_index (in_input_index),
    .in_data        (in_data),
    .in_last_input  (in_last_input),
    .out_valid      (out_valid),
    .out_neuron     (out_neuron),
    .out_activation (out_activation),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  logic signed [DATA_W-1:0] weight_mem [NEURONS][INPUTS];
  logic signed [ACC_W-1:0]  acc_sum [NEURONS];
  logic [ACT_W-1:0]         sig_lut [LUT_SIZE];
  logic [COUNT_W-1:0]       layer_size = 7'd1;
  neuron_result_t           result_q [$];
  neuron_result_t           want_res;
  layer_beat_t              beat_q [$];
  layer_beat_t              drv_beat;
  logic [NEURONS-1:0]       rows_written [INPUTS];
  bit                       col_ready [INPUTS];
  int                       feed_cols [$];
  int                       fill_cols [2] = '{8'h00, 8'hFF};
  int                       phase_sizes [6];
  int                       pushed_count = 0;
  int                       accepted_count = 0;
  int                       idle_left = 0;
  bit                       steady = 1'b0;
  int                       err_count = 0;

  function automatic longint unsigned exp_series(input longint unsigned f);
    longint unsigned total;
    longint unsigned term;
    total = 64'd1 << 32;
    term  = 64'd1 << 32;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    return total;
  endfunction

  function automatic logic [ACT_W-1:0] lut_entry(input int idx);
    longint unsigned em1;
    longint unsigned c;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned en;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    bit              neg;
    em1 = exp_series(64'd1 << 31);
    em1 = (em1 * em1) >> 32;
    c   = 64'(2 * idx + 1);
    neg = c < 64'(LUT_SIZE);
    mag = neg ? 64'(LUT_SIZE) - c : c - 64'(LUT_SIZE);
    a   = (mag << 35) / 64'(LUT_SIZE);
    en  = 64'd1 << 32;
    for (longint unsigned j = 0; j < (a >> 32); j++) begin
      en = (en * em1) >> 32;
    end
    e   = (en * exp_series(a & 64'hFFFF_FFFF)) >> 32;
    den = (64'd1 << 32) + e;
    s   = ((64'd1 << 44) + den / 2) / den;
    if (neg) begin
      s = 64'd4096 - s;
    end
    return s[ACT_W-1:0];
  endfunction

  function automatic logic [ACT_W-1:0] sigmoid_of(input logic signed [ACC_W-1:0] s);
    longint v;
    v = s;
    if (v < SUM_LO) begin
      v = SUM_LO;
    end
    if (v > SUM_HI) begin
      v = SUM_HI;
    end
    return sig_lut[(v - longint'(SUM_LO)) >> LUT_SHIFT];
  endfunction

  task automatic predict_layer(input layer_beat_t b);
    longint         sum;
    int             count;
    neuron_result_t r;
    if (b.func == FUNC_LOAD) begin
      weight_mem[b.row][b.col] = b.data;
    end else begin
      for (int n = 0; n < NEURONS; n++) begin
        sum = longint'(acc_sum[n]) + longint'(weight_mem[n][b.col]) * longint'(b.data);
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
        end
        if (sum < ACC_MIN) begin
          sum = ACC_MIN;
        end
        acc_sum[n] = sum[ACC_W-1:0];
      end
      if (b.last_in) begin
        count = int'(layer_size);
        if (count == 0) begin
          count = 1;
        end
        if (count > NEURONS) begin
          count = NEURONS;
        end
        for (int n = 0; n < count; n++) begin
          r.neuron  = n[NEURON_W-1:0];
          r.act     = sigmoid_of(acc_sum[n]);
          r.is_last = (n == count - 1);
          result_q.push_back(r);
        end
        for (int n = 0; n < NEURONS; n++) begin
          acc_sum[n] = '0;
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) begin
      return 0;
    end
    if (r < 80) begin
      return $urandom_range(4, 1);
    end
    if (r < 95) begin
      return $urandom_range(80, 5);
    end
    return $urandom_range(150, 81);
  endfunction

  function automatic int rand_value();
    if ($urandom_range(3) == 0) begin
      return int'($urandom_range(65535)) - 32768;
    end
    return int'($urandom_range(8192)) - 4096;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic add_beat(input logic func, input int row, input int col, input int data,
                          input logic last_in);
    layer_beat_t b;
    b.func    = func;
    b.row     = row[NEURON_W-1:0];
    b.col     = col[INDEX_W-1:0];
    b.data    = data[DATA_W-1:0];
    b.last_in = last_in;
    beat_q.push_back(b);
    pushed_count++;
    if (func == FUNC_LOAD) begin
      rows_written[b.col][b.row] = 1'b1;
      if (&rows_written[b.col] && !col_ready[b.col]) begin
        col_ready[b.col] = 1'b1;
        feed_cols.push_back(int'(b.col));
      end
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (accepted_count != pushed_count || result_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_layer_size(input int v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[COUNT_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    layer_size  = v[COUNT_W-1:0];
  endtask

  task automatic random_phase(input int n_items);
    int made;
    int len;
    int col;
    bit broken;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_beat(FUNC_LOAD, $urandom_range(NEURONS - 1), $urandom_range(INPUTS - 1),
                 rand_value(), $urandom_range(1));
        made++;
      end else begin
        len    = $urandom_range(6, 1);
        broken = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
          col = feed_cols[$urandom_range(feed_cols.size() - 1)];
          add_beat(FUNC_FEED, $urandom_range(NEURONS - 1), col, rand_value(),
                   (k == len - 1) && !broken);
        end
        made += len;
      end
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // beat driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_layer(drv_beat);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (beat_q.size() > 0) begin
          drv_beat         = beat_q.pop_front();
          in_func         <= drv_beat.func;
          in_neuron_index <= drv_beat.row;
          in_input_index  <= drv_beat.col;
          in_data         <= drv_beat.data;
          in_last_input   <= drv_beat.last_in;
          start           <= 1'b1;
          idle_left       <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        flag_error($sformatf("unexpected result neuron %0d activation %0d last %0d",
                             out_neuron, out_activation, out_last));
      end else begin
        want_res = result_q.pop_front();
        if (out_neuron !== want_res.neuron) begin
          flag_error($sformatf("neuron expected %0d got %0d", want_res.neuron, out_neuron));
        end
        if (out_activation !== want_res.act) begin
          flag_error($sformatf("activation of neuron %0d expected %0d got %0d",
                               want_res.neuron, want_res.act, out_activation));
        end
        if (out_last !== want_res.is_last) begin
          flag_error($sformatf("last of neuron %0d expected %0d got %0d",
                               want_res.neuron, want_res.is_last, out_last));
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < LUT_SIZE; i++) begin
      sig_lut[i] = lut_entry(i);
    end
    for (int n = 0; n < NEURONS; n++) begin
      acc_sum[n] = '0;
    end
    for (int c = 0; c < INPUTS; c++) begin
      rows_written[c] = '0;
      col_ready[c]    = 1'b0;
    end
    phase_sizes = '{0, 127, 1, 5, $urandom_range(63, 2), NEURONS};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_layer_size(NEURONS);

    // full weight columns, with extremes in column zero
    foreach (fill_cols[f]) begin
      for (int r = 0; r < NEURONS; r++) begin
        if (f == 0 && r == 0) begin
          add_beat(FUNC_LOAD, r, fill_cols[f], 32767, $urandom_range(1));
        end else if (f == 0 && r == 1) begin
          add_beat(FUNC_LOAD, r, fill_cols[f], -32768, $urandom_range(1));
        end else if (f == 0 && r < 5) begin
          add_beat(FUNC_LOAD, r, fill_cols[f], 3 - r, $urandom_range(1));
        end else begin
          add_beat(FUNC_LOAD, r, fill_cols[f], rand_value(), $urandom_range(1));
        end
      end
    end

    add_beat(FUNC_FEED, 63, 8'h00, 32767, 1'b0);
    add_beat(FUNC_FEED, 0, 8'hFF, -32768, 1'b1);
    add_beat(FUNC_FEED, 21, 8'hFF, 0, 1'b1);
    add_beat(FUNC_FEED, 42, 8'h00, 1, 1'b0);
    add_beat(FUNC_FEED, 0, 8'hFF, -1, 1'b1);
    add_beat(FUNC_LOAD, 63, 8'hFF, -32768, 1'b1);
    add_beat(FUNC_FEED, 0, 8'hFF, 4096, 1'b1);
    add_beat(FUNC_FEED, 0, 8'h00, 4096, 1'b1);
    add_beat(FUNC_FEED, 0, 8'h00, -4096, 1'b1);
    wait_idle();

    foreach (phase_sizes[p]) begin
      set_layer_size(phase_sizes[p]);
      steady = (p == 2);
      random_phase(10);
    end

    wait_idle();
    if (err_count == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
src/dls_pkg.sv
src/dls_ctrl.sv
src/dls_datapath.sv
src/dense_layer_sigmoid.sv
bench/dense_layer_sigmoid_test.sv
